// ===== src/dls_pkg.sv =====
// ----------------------------------------------------------------------------
// dls_pkg
// Shared types and constants for the decimal list splitter: the input and
// result transaction payloads, status codes and character class bounds.
// ----------------------------------------------------------------------------
`default_nettype none

package dls_pkg;

  // Default limit on the number of digits in one number.
  localparam int unsigned MaxDigitsDefault = 5;

  // Fixed payload widths.
  localparam int unsigned CharW   = 8;
  localparam int unsigned NumberW = 17;
  localparam int unsigned StatusW = 2;

  // Result status codes.
  localparam logic [StatusW-1:0] StEntry  = 2'd0;
  localparam logic [StatusW-1:0] StAccept = 2'd1;
  localparam logic [StatusW-1:0] StReject = 2'd2;

  // Character class bounds (ASCII).
  localparam logic [CharW-1:0] ChDigit0 = 8'h30;
  localparam logic [CharW-1:0] ChDigit9 = 8'h39;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ = 8'h7A;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;

  // One input transaction: a byte of the string and its framing.
  typedef struct packed {
    logic             has_char;
    logic [CharW-1:0] char_byte;
    logic             end_of_string;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [NumberW-1:0] number_value;
    logic [CharW-1:0]   separator_code;
  } out_item_t;

  // Result handed from the parser core to the output stage.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } dls_result_t;

  // True for an ASCII decimal digit.
  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= ChDigit0) && (c <= ChDigit9);
  endfunction

  // True for an ASCII letter or whitespace byte.
  function automatic logic is_letter_or_space(input logic [CharW-1:0] c);
    return ((c >= ChUpperA) && (c <= ChUpperZ)) ||
           ((c >= ChLowerA) && (c <= ChLowerZ)) ||
           (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

`default_nettype wire

// ===== src/dls_core.sv =====
// ----------------------------------------------------------------------------
// dls_core
// Parser state and per-byte step logic. Holds the phase, the value of the
// digits seen so far and the digit count, and computes the result that the
// presented item causes. State advances only when step_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module dls_core #(
  parameter int unsigned MaxDigits = dls_pkg::MaxDigitsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dls_pkg::in_item_t item_i,
  input  wire logic             step_i,
  output dls_pkg::dls_result_t  result_o
);

  // Accumulator holds up to MaxDigits decimal digits; the count holds MaxDigits.
  localparam int unsigned AccW  = $clog2(10 ** MaxDigits);
  localparam int unsigned CntW  = $clog2(MaxDigits + 1);
  localparam int unsigned WideW = 32;

  // One-hot parser phase.
  typedef enum logic [3:0] {
    PhInitial   = 4'b0001,
    PhSeparator = 4'b0010,
    PhDigit     = 4'b0100,
    PhError     = 4'b1000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic              byte_is_digit;
  logic              byte_is_bad;
  logic [3:0]        digit_val;
  logic [AccW+3:0]   acc_next_wide;
  logic [WideW-1:0]  acc_wide;
  logic [WideW-1:0]  acc_out_wide;
  dls_pkg::out_item_t res_item;
  logic              res_valid;

  // Character classification and the multiply-by-ten accumulate.
  always_comb begin
    byte_is_digit = dls_pkg::is_digit(item_i.char_byte);
    byte_is_bad   = dls_pkg::is_letter_or_space(item_i.char_byte);
    digit_val     = item_i.char_byte[3:0];
    acc_next_wide = ({4'b0000, acc_q} << 3) + ({4'b0000, acc_q} << 1) +
                    (AccW+4)'(digit_val);
    acc_wide      = WideW'(acc_q);
  end

  // Next state and result for the presented item.
  always_comb begin
    phase_d      = phase_q;
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    res_valid    = 1'b0;
    res_item     = '0;
    acc_out_wide = '0;

    if (item_i.has_char && (phase_q != PhError)) begin
      priority if (byte_is_digit) begin
        if (cnt_q < CntW'(MaxDigits)) begin
          acc_d   = acc_next_wide[AccW-1:0];
          cnt_d   = cnt_q + CntW'(1);
          phase_d = PhDigit;
        end else begin
          phase_d = PhError;
        end
      end else if (byte_is_bad) begin
        phase_d = PhError;
      end else if ((phase_q == PhDigit) && (acc_q != '0)) begin
        // A separator closes the current number.
        if (!item_i.end_of_string) begin
          res_valid               = 1'b1;
          res_item.status         = dls_pkg::StEntry;
          res_item.number_value   = acc_wide[dls_pkg::NumberW-1:0];
          res_item.separator_code = item_i.char_byte;
        end
        acc_d   = '0;
        cnt_d   = '0;
        phase_d = PhSeparator;
      end else begin
        phase_d = PhError;
      end
    end

    // String end: report the final number or the reject, then start over.
    if (item_i.end_of_string) begin
      res_valid    = 1'b1;
      acc_out_wide = WideW'(acc_d);
      if ((phase_d == PhDigit) && (acc_d != '0)) begin
        res_item.status       = dls_pkg::StAccept;
        res_item.number_value = acc_out_wide[dls_pkg::NumberW-1:0];
      end else begin
        res_item.status       = dls_pkg::StReject;
        res_item.number_value = '0;
      end
      res_item.separator_code = '0;
      phase_d = PhInitial;
      acc_d   = '0;
      cnt_d   = '0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhInitial;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  assign result_o.valid = res_valid;
  assign result_o.item  = res_item;

endmodule

`default_nettype wire

// ===== src/decimal_list_splitter.sv =====
// ----------------------------------------------------------------------------
// decimal_list_splitter
// Splits a byte stream into decimal numbers joined by single separators.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_item_i) takes one byte of
//   a string per transaction, with has_char and end_of_string framing. The
//   output channel (out_valid_o / out_ready_i / out_item_o) gives at most one
//   result per input transaction: an entry when a separator closes a number,
//   and at string end either the final entry (accepted) or a reject, after
//   which the receiver drops the entries it already got for that string.
//   Throughput is one input transaction per cycle while no result waits on a
//   stalled receiver. An accepted byte is registered in the input register,
//   and the result the parser makes of it is registered in the output
//   register. When the receiver stalls, the output register holds its
//   result; one more byte waits in the input register, and in_ready_o drops
//   only when that byte would produce a result with no room to put it.
//   Bytes that produce no result keep flowing during a stall.
//   Reset clears both stages and puts the parser at the start of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_list_splitter #(
  parameter int unsigned MaxDigits = dls_pkg::MaxDigitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dls_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dls_pkg::out_item_t     out_item_o
);

  logic                 in_valid_q;
  dls_pkg::in_item_t    in_item_q;
  logic                 out_valid_q;
  dls_pkg::out_item_t   out_item_q;
  dls_pkg::dls_result_t result;
  logic                 out_free;
  logic                 step;
  logic                 in_fire;

  // Parser core works on the registered byte.
  dls_core #(
    .MaxDigits(MaxDigits)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_item_q),
    .step_i  (step),
    .result_o(result)
  );

  // Flow control between the two stages.
  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    step       = in_valid_q && (!result.valid || out_free);
    in_ready_o = !in_valid_q || step;
    in_fire    = in_valid_i && in_ready_o;
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= in_item_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && result.valid) begin
      out_item_q <= result.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A reject carries no number and no separator.
  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == dls_pkg::StReject) |->
      (out_item_o.number_value == '0) && (out_item_o.separator_code == '0))
    else $error("reject result carries data");

  // The final entry of an accepted string has no separator.
  a_accept_nosep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == dls_pkg::StAccept) |->
      (out_item_o.separator_code == '0))
    else $error("accepted final entry has a separator");

  // An ordinary entry is closed by a true separator, never by a digit.
  a_entry_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == dls_pkg::StEntry) |->
      !dls_pkg::is_digit(out_item_o.separator_code) &&
      !dls_pkg::is_letter_or_space(out_item_o.separator_code))
    else $error("entry closed by a non-separator byte");

  // An accepted byte always lands in the input register.
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_valid_q)
    else $error("accepted byte lost");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for decimal_list_splitter. A behavioral model of the
// parser predicts the result of every accepted byte. The checker compares
// each delivered result, field by field, with the oldest prediction. The
// stimulus is a directed set of lists and rejects, followed by random lists
// under three idling mixes on the two channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxDigits = dls_pkg::MaxDigitsDefault;
  localparam int unsigned TimeoutNs = 2_000_000;

  // Parser phases of the behavioral model.
  typedef enum logic [1:0] {
    PhStart,
    PhAfterSep,
    PhInNumber,
    PhFault
  } parse_phase_e;

  // Byte classes as the splitter sees them.
  typedef enum logic [1:0] {
    ChrDigit,
    ChrWordOrSpace,
    ChrSeparator
  } char_class_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  dls_pkg::in_item_t  in_item = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  dls_pkg::out_item_t out_item;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned failures = 0;

  // Model state and the queue of results it still expects.
  parse_phase_e                parse_phase = PhStart;
  logic [dls_pkg::NumberW-1:0] number_acc = '0;
  logic [2:0]                  digit_total = '0;
  dls_pkg::out_item_t          pending_results[$];

  decimal_list_splitter dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #2 clk = ~clk;

  // Classify one byte: digit, letter or whitespace, or anything else.
  function automatic char_class_e classify(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return ChrDigit;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
        c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return ChrWordOrSpace;
    return ChrSeparator;
  endfunction

  // Advance the model by one accepted transaction and queue its result.
  function automatic void predict_results(input dls_pkg::in_item_t item);
    if (item.has_char && parse_phase != PhFault) begin
      case (classify(item.char_byte))
        ChrDigit: begin
          if (digit_total < MaxDigits) begin
            number_acc  = dls_pkg::NumberW'(number_acc * 10 +
                          dls_pkg::NumberW'(item.char_byte - 8'h30));
            digit_total = digit_total + 3'd1;
            parse_phase = PhInNumber;
          end else begin
            parse_phase = PhFault;
          end
        end
        ChrWordOrSpace: begin
          parse_phase = PhFault;
        end
        default: begin
          // A separator closes a nonzero number; a separator at the end
          // of the string is left for the end-of-string check below.
          if (parse_phase == PhInNumber && number_acc != 0) begin
            if (!item.end_of_string) begin
              pending_results.push_back(dls_pkg::out_item_t'{
                status: dls_pkg::StEntry, number_value: number_acc,
                separator_code: item.char_byte});
            end
            number_acc  = '0;
            digit_total = '0;
            parse_phase = PhAfterSep;
          end else begin
            parse_phase = PhFault;
          end
        end
      endcase
    end
    if (item.end_of_string) begin
      if (parse_phase == PhInNumber && number_acc != 0) begin
        pending_results.push_back(dls_pkg::out_item_t'{
          status: dls_pkg::StAccept, number_value: number_acc,
          separator_code: '0});
      end else begin
        pending_results.push_back(dls_pkg::out_item_t'{
          status: dls_pkg::StReject, number_value: '0, separator_code: '0});
      end
      parse_phase = PhStart;
      number_acc  = '0;
      digit_total = '0;
    end
  endfunction

  // Count a failure and report it while the report budget lasts.
  task automatic note_failure(input string what, input dls_pkg::out_item_t want,
                              input dls_pkg::out_item_t got);
    failures++;
    if (failures <= 10) begin
      $display("%t %s: expected status %0d value %0d sep 0x%02h,",
               $realtime, what, want.status, want.number_value,
               want.separator_code,
               " got status %0d value %0d sep 0x%02h",
               got.status, got.number_value, got.separator_code);
    end
  endtask

  // The receiver stalls at random according to the current mix.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check every result transaction against the oldest prediction.
  always @(posedge clk) begin
    dls_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_failure("unexpected result", '0, out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status ||
            out_item.number_value !== want.number_value ||
            out_item.separator_code !== want.separator_code) begin
          note_failure("result mismatch", want, out_item);
        end
      end
    end
  end

  // Send one input transaction, with random idle cycles ahead of it.
  task automatic send_item(input logic has, input logic [7:0] c, input logic eos);
    dls_pkg::in_item_t item;
    item = dls_pkg::in_item_t'{has_char: has, char_byte: c, end_of_string: eos};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    predict_results(item);
  endtask

  // Send a text as one string, ending it on its last byte if asked.
  task automatic send_text(input string s, input bit last_is_end);
    for (int i = 0; i < s.len(); i++) begin
      send_item(1'b1, s[i], last_is_end && (i == s.len() - 1));
    end
  endtask

  // Send a byte list as one string, with some ignored byteless items mixed
  // in; the string ends on its last byte or on a separate end marker.
  task automatic send_bytes(input logic [7:0] chars[$], input bit end_marker,
                            input int unsigned skip_pct);
    for (int i = 0; i < chars.size(); i++) begin
      if ($urandom_range(99) < skip_pct) send_item(1'b0, 8'($urandom_range(255)), 1'b0);
      send_item(1'b1, chars[i], (i == chars.size() - 1) && !end_marker);
    end
    if (end_marker || chars.size() == 0) begin
      send_item(1'b0, 8'($urandom_range(255)), 1'b1);
    end
  endtask

  function automatic logic [7:0] random_separator();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (classify(c) != ChrSeparator);
    return c;
  endfunction

  function automatic logic [7:0] random_word_or_space();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (classify(c) != ChrWordOrSpace);
    return c;
  endfunction

  // Append a number of the given length; now and then with a leading zero.
  function automatic void append_number(ref logic [7:0] chars[$],
                                        input int unsigned digits);
    for (int i = 0; i < digits; i++) begin
      if (i == 0 && $urandom_range(9) != 0) begin
        chars.push_back(8'h30 + 8'($urandom_range(1, 9)));
      end else begin
        chars.push_back(8'h30 + 8'($urandom_range(9)));
      end
    end
  endfunction

  // Accepted lists: largest value, high and null separator bytes, a leading
  // zero, an ignored byteless item, and both ways to end a string.
  task automatic test_accepted_lists();
    send_text("7", 1'b1);
    send_text("99999", 1'b0);
    send_item(1'b1, 8'h80, 1'b0);
    send_item(1'b1, 8'h31, 1'b0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_text("02", 1'b0);
    send_item(1'b0, 8'h41, 1'b0);
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'h33, 1'b0);
    send_item(1'b0, 8'h00, 1'b1);
  endtask

  // Rejected strings, one for each kind of fault.
  task automatic test_rejected_lists();
    // Empty string.
    send_item(1'b0, 8'h00, 1'b1);
    // Zero value.
    send_text("0", 1'b1);
    // Leading, doubled and trailing separators.
    send_text(",5", 1'b1);
    send_text("5;;6", 1'b1);
    send_text("5,", 1'b1);
    // A letter, then digits that must be ignored; then whitespace.
    send_text("5x7", 1'b1);
    send_text("5\t", 1'b1);
    // Too many digits.
    send_text("123456", 1'b1);
  endtask

  // Random lists: mostly well formed, some with one defect, some noise.
  task automatic test_random_lists(input int unsigned item_budget);
    logic [7:0]  chars[$];
    int unsigned sent;
    int unsigned kind;
    int unsigned idx;
    sent = 0;
    while (sent < item_budget) begin
      chars = {};
      kind  = $urandom_range(99);
      if (kind < 90) begin
        for (int n = 0; n < $urandom_range(1, 4); n++) begin
          if (n != 0) chars.push_back(random_separator());
          append_number(chars, $urandom_range(1, MaxDigits));
        end
      end else begin
        repeat ($urandom_range(0, 8)) chars.push_back(8'($urandom_range(255)));
      end
      // Break some of the well-formed lists in one place.
      if (kind >= 70 && kind < 90) begin
        idx = $urandom_range(chars.size() - 1);
        case ($urandom_range(6))
          0: chars[idx] = 8'($urandom_range(255));
          1: chars.insert(idx, random_separator());
          2: chars.push_back(random_separator());
          3: chars.push_front(random_separator());
          4: begin
            chars.push_back(random_separator());
            append_number(chars, MaxDigits + $urandom_range(1, 2));
          end
          5: begin
            chars.push_back(random_separator());
            repeat ($urandom_range(1, MaxDigits)) chars.push_back(8'h30);
          end
          default: chars.insert(idx, random_word_or_space());
        endcase
      end
      send_bytes(chars, $urandom_range(3) == 0, 4);
      sent += chars.size() + 1;
    end
  endtask

  // Main sequence: reset, directed tests, random tests under three mixes.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 30;
    recv_idle_pct = 74;
    test_accepted_lists();
    test_rejected_lists();
    test_random_lists(175);
    send_idle_pct = 74;
    recv_idle_pct = 30;
    test_random_lists(175);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lists(175);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      failures += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end
    if (failures == 0) begin
      $display("** decimal_list_splitter: PASSED **");
    end else begin
      $display("** decimal_list_splitter: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TimeoutNs);
    $display("** decimal_list_splitter: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
